FILE: hw/rtl/dcp_pkg.sv
// shared types and constants of the distance constraint projection
package dcp_pkg;

  localparam int SQ_BITS  = 34;
  localparam int SUM_W    = 67;
  localparam int DEN_W    = 67;
  localparam int NUM_W    = 98;
  localparam int DIV_QB   = 35;
  localparam int DIV_LAT  = DIV_QB + 1;
  localparam logic [31:0] REST_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [31:0]      wa;
    logic [31:0]      wb;
    logic [32:0]      w;
    logic [2:0][32:0] md;
    logic [2:0]       dneg;
  } sq_pay_t;

  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [2:0]       dneg;
    logic             lr_neg;
    logic             degen;
  } div_pay_t;

endpackage

FILE: hw/rtl/dcp_div.sv
// pipelined restoring divider with round-half-up, one quotient bit per stage
module dcp_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [dcp_pkg::NUM_W-1:0]    num_i,
  input  logic [dcp_pkg::DEN_W-1:0]    den_i,
  output logic [dcp_pkg::DIV_QB:0]     q_o
);
  import dcp_pkg::*;

  logic [DEN_W-1:0]  rem_in [0:DIV_QB-1];
  logic [DEN_W-1:0]  den_in [0:DIV_QB-1];
  logic [DIV_QB-1:0] num_in [0:DIV_QB-1];
  logic [DIV_QB-1:0] q_in   [0:DIV_QB-1];

  logic [DEN_W-1:0]  rem_r [1:DIV_QB];
  logic [DEN_W-1:0]  den_r [1:DIV_QB];
  logic [DIV_QB-1:0] num_r [1:DIV_QB];
  logic [DIV_QB-1:0] q_r   [1:DIV_QB];
  logic [DIV_QB:0]   q_out_r;

  assign rem_in[0] = DEN_W'(num_i[NUM_W-1:DIV_QB]);
  assign den_in[0] = den_i;
  assign num_in[0] = num_i[DIV_QB-1:0];
  assign q_in[0]   = '0;

  for (genvar j = 0; j < DIV_QB; j++) begin : g_step
    localparam int BI = DIV_QB - 1 - j;
    logic [DEN_W:0] rem2;
    logic           ge;
    if (j > 0) begin : g_link
      assign rem_in[j] = rem_r[j];
      assign den_in[j] = den_r[j];
      assign num_in[j] = num_r[j];
      assign q_in[j]   = q_r[j];
    end
    always_comb begin
      rem2 = {rem_in[j], num_in[j][BI]};
      ge   = rem2 >= {1'b0, den_in[j]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? DEN_W'(rem2 - {1'b0, den_in[j]}) : DEN_W'(rem2);
        den_r[j+1] <= den_in[j];
        num_r[j+1] <= num_in[j];
        q_r[j+1]   <= q_in[j] | (DIV_QB'(ge) << BI);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_out_r <= {1'b0, q_r[DIV_QB]} +
                 (DIV_QB+1)'({rem_r[DIV_QB], 1'b0} >= {1'b0, den_r[DIV_QB]});
    end
  end

  assign q_o = q_out_r;

endmodule

FILE: hw/rtl/distance_constraint_projection.sv
// throughput: one item per cycle while the output is not stalled, set by the bit-per-stage square root and dividers
// the whole pipeline holds while a result waits; the input stage still takes an item if empty
// reset (synchronous, active low) empties the pipeline and sets rest_length to 1.0
// top level: distance constraint projection
module distance_constraint_projection (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, inv_mass_a, inv_mass_b
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z
  output logic [191:0] out_tdata,
  // degenerate
  output logic [0:0]   out_tuser
);
  import dcp_pkg::*;

  localparam int NV = 3 + SQ_BITS + 3 + DIV_LAT + 1;

  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) return 32'h7fff_ffff;
    else if (v < -38'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  logic [31:0] rest_r;
  logic        s0_v_r;
  logic [NV-1:0] vld_r;
  logic        adv;

  logic [2:0][31:0] s0_a_r, s0_b_r;
  logic [31:0]      s0_wa_r, s0_wb_r;

  sq_pay_t                p1_r, p2_r;
  logic [2:0][65:0]       sq_r;
  logic [SUM_W-1:0]       sqr_rem_r  [0:SQ_BITS];
  logic [SQ_BITS-1:0]     sqr_root_r [0:SQ_BITS];
  sq_pay_t                sqr_pay_r  [0:SQ_BITS];

  div_pay_t               l1_pay_r, l2_pay_r, l3_pay_r;
  logic [DEN_W-1:0]       l1_den_r, l2_den_r, l3_den_r;
  logic [34:0]            l1_mag_r;
  logic [2:0][63:0]       l1_pa_r, l1_pb_r;
  logic [2:0][66:0]       l2_pal_r, l2_pah_r, l2_pbl_r, l2_pbh_r;
  logic [2:0][NUM_W-1:0]  l3_na_r, l3_nb_r;
  div_pay_t               dpay_r [0:DIV_LAT-1];
  logic [2:0][DIV_QB:0]   qa, qb;

  logic [191:0] out_data_r;
  logic         out_degen_r;

  assign adv        = !vld_r[NV-1] || out_tready;
  assign in_tready  = adv || !s0_v_r;
  assign out_tvalid = vld_r[NV-1];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= REST_RESET;
      s0_v_r <= 1'b0;
      vld_r  <= '0;
    end else begin
      if (cfg_we) begin
        rest_r <= cfg_wdata;
      end
      if (in_tready) begin
        s0_v_r <= in_tvalid;
      end
      if (adv) begin
        vld_r <= {vld_r[NV-2:0], s0_v_r};
      end
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (in_tready) begin
      for (int i = 0; i < 3; i++) begin
        s0_a_r[i] <= in_tdata[32*i +: 32];
        s0_b_r[i] <= in_tdata[96 + 32*i +: 32];
      end
      s0_wa_r <= in_tdata[223:192];
      s0_wb_r <= in_tdata[255:224];
    end
  end

  // differences
  logic signed [2:0][32:0] d_nxt;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = $signed({s0_b_r[i][31], s0_b_r[i]}) - $signed({s0_a_r[i][31], s0_a_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r.a  <= s0_a_r;
      p1_r.b  <= s0_b_r;
      p1_r.wa <= s0_wa_r;
      p1_r.wb <= s0_wb_r;
      p1_r.w  <= {1'b0, s0_wa_r} + {1'b0, s0_wb_r};
      for (int i = 0; i < 3; i++) begin
        p1_r.dneg[i] <= d_nxt[i][32];
        p1_r.md[i]   <= d_nxt[i][32] ? 33'(-d_nxt[i]) : 33'(d_nxt[i]);
      end
    end
  end

  // squares, then sum
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r <= p1_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 66'(p1_r.md[i] * p1_r.md[i]);
      end
      sqr_pay_r[0]  <= p2_r;
      sqr_rem_r[0]  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      sqr_root_r[0] <= '0;
    end
  end

  // square root, one root bit per stage
  for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
    localparam int K = SQ_BITS - 1 - j;
    logic [SUM_W:0] trial;
    logic           ge;
    always_comb begin
      trial = ({(SUM_W+1-SQ_BITS)'(0), sqr_root_r[j]} << (K+1)) | ((SUM_W+1)'(1) << (2*K));
      ge    = {1'b0, sqr_rem_r[j]} >= trial;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sqr_pay_r[j+1]  <= sqr_pay_r[j];
        sqr_rem_r[j+1]  <= ge ? SUM_W'({1'b0, sqr_rem_r[j]} - trial) : sqr_rem_r[j];
        sqr_root_r[j+1] <= sqr_root_r[j] | (SQ_BITS'(ge) << K);
      end
    end
  end

  // length terms, denominator and mass products
  sq_pay_t            lp;
  logic [SQ_BITS-1:0] len;
  logic signed [35:0] lr_nxt;
  assign lp     = sqr_pay_r[SQ_BITS];
  assign len    = sqr_root_r[SQ_BITS];
  assign lr_nxt = $signed({2'b00, len}) - $signed({4'b0000, rest_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_pay_r.a      <= lp.a;
      l1_pay_r.b      <= lp.b;
      l1_pay_r.dneg   <= lp.dneg;
      l1_pay_r.lr_neg <= lr_nxt[35];
      l1_pay_r.degen  <= (len == '0) || (lp.w == '0);
      l1_mag_r        <= lr_nxt[35] ? 35'(-lr_nxt) : 35'(lr_nxt);
      l1_den_r        <= DEN_W'(len * lp.w);
      for (int i = 0; i < 3; i++) begin
        l1_pa_r[i] <= 64'(lp.md[i] * lp.wa);
        l1_pb_r[i] <= 64'(lp.md[i] * lp.wb);
      end
    end
  end

  // partial products of the numerators
  always_ff @(posedge clk) begin
    if (adv) begin
      l2_pay_r <= l1_pay_r;
      l2_den_r <= l1_den_r;
      for (int i = 0; i < 3; i++) begin
        l2_pal_r[i] <= 67'(l1_pa_r[i][31:0] * l1_mag_r);
        l2_pah_r[i] <= 67'(l1_pa_r[i][63:32] * l1_mag_r);
        l2_pbl_r[i] <= 67'(l1_pb_r[i][31:0] * l1_mag_r);
        l2_pbh_r[i] <= 67'(l1_pb_r[i][63:32] * l1_mag_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l3_pay_r <= l2_pay_r;
      l3_den_r <= l2_den_r;
      for (int i = 0; i < 3; i++) begin
        l3_na_r[i] <= NUM_W'(l2_pal_r[i]) + (NUM_W'(l2_pah_r[i]) << 32);
        l3_nb_r[i] <= NUM_W'(l2_pbl_r[i]) + (NUM_W'(l2_pbh_r[i]) << 32);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    dcp_div u_div_a (.clk(clk), .en(adv), .num_i(l3_na_r[i]), .den_i(l3_den_r), .q_o(qa[i]));
    dcp_div u_div_b (.clk(clk), .en(adv), .num_i(l3_nb_r[i]), .den_i(l3_den_r), .q_o(qb[i]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dpay_r[0] <= l3_pay_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dpay_r[k] <= dpay_r[k-1];
      end
    end
  end

  // apply corrections with saturation, or pass the positions through unchanged when degenerate
  div_pay_t           fp;
  logic [191:0]       res_nxt;
  logic signed [37:0] ca, cb, sa, sb;
  assign fp = dpay_r[DIV_LAT-1];

  always_comb begin
    res_nxt = '0;
    ca = '0;
    cb = '0;
    sa = '0;
    sb = '0;
    for (int i = 0; i < 3; i++) begin
      ca = $signed({2'b00, qa[i]});
      cb = $signed({2'b00, qb[i]});
      if (fp.dneg[i] ^ fp.lr_neg) begin
        ca = -ca;
        cb = -cb;
      end
      sa = $signed({{6{fp.a[i][31]}}, fp.a[i]}) + ca;
      sb = $signed({{6{fp.b[i][31]}}, fp.b[i]}) - cb;
      if (fp.degen) begin
        res_nxt[32*i +: 32]      = fp.a[i];
        res_nxt[96 + 32*i +: 32] = fp.b[i];
      end else begin
        res_nxt[32*i +: 32]      = sat32(sa);
        res_nxt[96 + 32*i +: 32] = sat32(sb);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r  <= res_nxt;
      out_degen_r <= fp.degen;
    end
  end

endmodule
